>>> rtl/lcht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcht_pkg: shared types and constants for the lba to chs translator
// Head-count codes, reciprocal constants and stage count of the pipeline.
// ----------------------------------------------------------------------------
package lcht_pkg;

  localparam int unsigned NUM_STAGES = 6;

  localparam int unsigned LBA_W = 24;
  localparam int unsigned Q1_W  = 19;
  localparam int unsigned CYL_W = 15;

  localparam logic [31:0] CLAMP_LBA  = 32'd16370046;
  localparam logic [31:0] LARGE_DISK = 32'd16450560;
  localparam logic [31:0] SIZE_H32   = 32'd1033200;
  localparam logic [31:0] SIZE_H64   = 32'd2066400;
  localparam logic [31:0] SIZE_H128  = 32'd4132800;
  localparam logic [31:0] SIZE_H255  = 32'd8265600;

  localparam logic [24:0] RECIP63       = 25'd17043521;
  localparam int unsigned RECIP63_SHIFT = 30;
  localparam logic [18:0] RECIP255       = 19'd263172;
  localparam int unsigned RECIP255_SHIFT = 26;

  localparam logic [6:0] SECTORS   = 7'd63;
  localparam logic [8:0] HEADS_MAX = 9'd255;

  localparam logic [7:0] CLAMP_CYL_LOW = 8'hFF;
  localparam logic [7:0] CLAMP_HEAD    = 8'd254;
  localparam logic [7:0] CLAMP_SCH     = 8'hFF;

  typedef enum logic [2:0] {
    HEADS_16,
    HEADS_32,
    HEADS_64,
    HEADS_128,
    HEADS_255
  } heads_sel_e;

  typedef struct packed {
    heads_sel_e  sel;
    logic [7:0]  heads;
  } geom_t;

endpackage
`default_nettype wire

>>> rtl/lba_to_chs_translate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lba_to_chs_translate: logical block address to packed mbr chs bytes
// Six-stage pipeline of two divisions with correction steps.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output side is not stalled; a stall
// backs up stage by stage with no loss. The depth comes from two divisions,
// first by 63 sectors (reciprocal multiply, subtract, one-step correction),
// then by the head count (shift and subtract for 16 to 128 heads, and as the
// first for 255). The head count (16, 32, 64, 128 or 255) is worked out from
// the disk size when it is written and takes effect from the next cycle;
// write it only with no request in flight. Addresses at or above 1023*254*63
// return cylinder 1023, head 254, sector 63 with clamped_o set; cylinder bits
// above bit 9 are dropped.
module lba_to_chs_translate import lcht_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] lba_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       cylinder_low_o,
  output logic [7:0]       head_o,
  output logic [7:0]       sector_cyl_high_o,
  output logic [7:0]       heads_used_o,
  output logic             clamped_o
);

  geom_t geom;

  lcht_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom)
  );

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: clamp check and quotient estimate by 63
  logic [LBA_W+24:0] p1;
  logic [LBA_W-1:0]  s1_x_q;
  logic [Q1_W-1:0]   s1_q0_q;
  logic              s1_clamp_q;

  assign p1 = (LBA_W+25)'(lba_i[LBA_W-1:0]) * (LBA_W+25)'(RECIP63);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_x_q     <= lba_i[LBA_W-1:0];
      s1_q0_q    <= p1[RECIP63_SHIFT +: Q1_W];
      s1_clamp_q <= (lba_i >= CLAMP_LBA);
    end
  end

  // stage 2: remainder against the estimate
  logic [LBA_W:0]  mul63;
  logic [LBA_W:0]  r0_full;
  logic [Q1_W-1:0] s2_q0_q;
  logic [6:0]      s2_r0_q;
  logic            s2_clamp_q;

  assign mul63   = {s1_q0_q, 6'b0} - (LBA_W+1)'(s1_q0_q);
  assign r0_full = {1'b0, s1_x_q} - mul63;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_q0_q    <= s1_q0_q;
      s2_r0_q    <= r0_full[6:0];
      s2_clamp_q <= s1_clamp_q;
    end
  end

  // stage 3: correction gives track number and sector index
  logic            ge63;
  logic [6:0]      r0_fix;
  logic [Q1_W-1:0] s3_q1_q;
  logic [5:0]      s3_sec_q;
  logic            s3_clamp_q;

  assign ge63   = (s2_r0_q >= SECTORS);
  assign r0_fix = ge63 ? (s2_r0_q - SECTORS) : s2_r0_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_q1_q    <= s2_q0_q + Q1_W'(ge63);
      s3_sec_q   <= r0_fix[5:0];
      s3_clamp_q <= s2_clamp_q;
    end
  end

  // stage 4: cylinder estimate by head count
  logic [2*Q1_W-1:0] p2;
  logic [CYL_W-1:0]  d_est;
  logic [CYL_W-1:0]  s4_d_q;
  logic [Q1_W-1:0]   s4_q1_q;
  logic [5:0]        s4_sec_q;
  logic              s4_clamp_q;

  assign p2 = (2*Q1_W)'(s3_q1_q) * (2*Q1_W)'(RECIP255);

  always_comb begin
    unique case (geom.sel)
      HEADS_16:  d_est = CYL_W'(s3_q1_q >> 4);
      HEADS_32:  d_est = CYL_W'(s3_q1_q >> 5);
      HEADS_64:  d_est = CYL_W'(s3_q1_q >> 6);
      HEADS_128: d_est = CYL_W'(s3_q1_q >> 7);
      HEADS_255: d_est = CYL_W'(p2 >> RECIP255_SHIFT);
      default:   d_est = CYL_W'(s3_q1_q >> 4);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_d_q     <= d_est;
      s4_q1_q    <= s3_q1_q;
      s4_sec_q   <= s3_sec_q;
      s4_clamp_q <= s3_clamp_q;
    end
  end

  // stage 5: head remainder against the estimate
  logic [CYL_W+7:0] hd;
  logic [CYL_W+7:0] r2_full;
  logic [CYL_W-1:0] s5_d_q;
  logic [8:0]       s5_r2_q;
  logic [5:0]       s5_sec_q;
  logic             s5_clamp_q;

  always_comb begin
    unique case (geom.sel)
      HEADS_16:  hd = (CYL_W+8)'(s4_d_q) << 4;
      HEADS_32:  hd = (CYL_W+8)'(s4_d_q) << 5;
      HEADS_64:  hd = (CYL_W+8)'(s4_d_q) << 6;
      HEADS_128: hd = (CYL_W+8)'(s4_d_q) << 7;
      HEADS_255: hd = {s4_d_q, 8'b0} - (CYL_W+8)'(s4_d_q);
      default:   hd = (CYL_W+8)'(s4_d_q) << 4;
    endcase
  end

  assign r2_full = (CYL_W+8)'(s4_q1_q) - hd;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_d_q     <= s4_d_q;
      s5_r2_q    <= r2_full[8:0];
      s5_sec_q   <= s4_sec_q;
      s5_clamp_q <= s4_clamp_q;
    end
  end

  // stage 6: correction and byte packing
  logic             fix255;
  logic [CYL_W-1:0] cyl;
  logic [8:0]       r2_fix;
  logic [5:0]       sector;
  logic [7:0]       cyl_low_q, head_q, sch_q;
  logic             clamp_q;

  assign fix255 = (geom.sel == HEADS_255) && (s5_r2_q >= HEADS_MAX);
  assign cyl    = s5_d_q + CYL_W'(fix255);
  assign r2_fix = fix255 ? (s5_r2_q - HEADS_MAX) : s5_r2_q;
  assign sector = s5_sec_q + 6'd1;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      clamp_q <= s5_clamp_q;
      if (s5_clamp_q) begin
        cyl_low_q <= CLAMP_CYL_LOW;
        head_q    <= CLAMP_HEAD;
        sch_q     <= CLAMP_SCH;
      end else begin
        cyl_low_q <= cyl[7:0];
        head_q    <= r2_fix[7:0];
        sch_q     <= {cyl[9:8], sector};
      end
    end
  end

  assign out_valid_o       = vld_q[NUM_STAGES-1];
  assign cylinder_low_o    = cyl_low_q;
  assign head_o            = head_q;
  assign sector_cyl_high_o = sch_q;
  assign heads_used_o      = geom.heads;
  assign clamped_o         = clamp_q;

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !clamped_o |-> head_o < heads_used_o)
    else $error("head not below head count");

  a_sector_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sector_cyl_high_o[5:0] != 6'd0)
    else $error("sector number zero");

  a_clamp_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |-> cylinder_low_o == CLAMP_CYL_LOW &&
      head_o == CLAMP_HEAD && sector_cyl_high_o == CLAMP_SCH)
    else $error("clamped request with wrong chs");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_ready_i |-> !in_ready_o)
    else $error("request taken into a full stalled pipeline");

  a_heads_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heads_used_o == 8'd16 || heads_used_o == 8'd32 ||
      heads_used_o == 8'd64 || heads_used_o == 8'd128 || heads_used_o == 8'd255)
    else $error("illegal head count");

endmodule
`default_nettype wire

>>> rtl/lcht_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcht_geom: disk geometry register
// Holds the head count chosen from the disk size written on the config port.
// ----------------------------------------------------------------------------
module lcht_geom import lcht_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output geom_t            geom_o
);

  heads_sel_e sel_d, sel_q;

  always_comb begin
    sel_d = sel_q;
    if (cfg_we_i) begin
      priority if (cfg_wdata_i >= LARGE_DISK) sel_d = HEADS_255;
      else if (cfg_wdata_i >= SIZE_H255)      sel_d = HEADS_255;
      else if (cfg_wdata_i >= SIZE_H128)      sel_d = HEADS_128;
      else if (cfg_wdata_i >= SIZE_H64)       sel_d = HEADS_64;
      else if (cfg_wdata_i >= SIZE_H32)       sel_d = HEADS_32;
      else                                    sel_d = HEADS_16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= HEADS_16;
    end else begin
      sel_q <= sel_d;
    end
  end

  always_comb begin
    geom_o.sel = sel_q;
    unique case (sel_q)
      HEADS_16:  geom_o.heads = 8'd16;
      HEADS_32:  geom_o.heads = 8'd32;
      HEADS_64:  geom_o.heads = 8'd64;
      HEADS_128: geom_o.heads = 8'd128;
      HEADS_255: geom_o.heads = 8'd255;
      default:   geom_o.heads = 8'd16;
    endcase
  end

endmodule
`default_nettype wire

>>> test/lba_to_chs_translate_tb.sv
// ----------------------------------------------------------------------------
// lba_to_chs_translate_tb: self-checking bench for the lba to chs translator
// Streams addresses through the block over a range of disk sizes and checks
// every packed cylinder/head/sector result against an in-bench prediction,
// with random idling on both sides, a long output stall and full drains.
// ----------------------------------------------------------------------------
module lba_to_chs_translate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcht_pkg::*;

  localparam logic [31:0] SECT_PER_TRACK   = 32'd63;
  localparam logic [31:0] BASE_DIVISOR     = 32'd16 * 32'd63;
  localparam logic [31:0] LARGE_DISK_SIZE  = 32'd1024 * 32'd255 * 32'd63;
  localparam logic [31:0] CLAMP_ADDR       = 32'd1023 * 32'd254 * 32'd63;
  localparam int unsigned NUM_PHASES       = 15;
  localparam int unsigned ITEMS_PER_PHASE  = 84;
  localparam int unsigned LONG_STALL_CYCLES = 300;

  typedef struct packed {
    logic [7:0] cylinder_low;
    logic [7:0] head;
    logic [7:0] sector_cyl_high;
    logic [7:0] heads_used;
    logic       clamped;
  } chs_result_t;

  class chs_scoreboard;
    logic [31:0] disk_size;
    chs_result_t chs_q[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned clamped_count;

    function new();
      disk_size     = '0;
      mismatches    = 0;
      requests      = 0;
      clamped_count = 0;
    endfunction

    function logic [7:0] heads_for_size(logic [31:0] size);
      logic [31:0] cyl_est;
      logic [8:0]  heads;
      if (size >= LARGE_DISK_SIZE) return 8'd255;
      cyl_est = size / BASE_DIVISOR;
      heads   = 9'd16;
      while (cyl_est > 32'd1024) begin
        heads   = heads << 1;
        cyl_est = cyl_est >> 1;
      end
      if (heads > 9'd255) heads = 9'd255;
      return heads[7:0];
    endfunction

    function chs_result_t translate_lba(logic [31:0] lba);
      chs_result_t r;
      logic [31:0] heads;
      logic [31:0] per_cyl;
      logic [31:0] cyl;
      logic [31:0] rem;
      logic [31:0] hd;
      logic [31:0] sect;
      logic [31:0] sch;
      heads = {24'd0, heads_for_size(disk_size)};
      if (lba >= CLAMP_ADDR) begin
        cyl       = 32'd1023;
        hd        = 32'd254;
        sect      = 32'd63;
        r.clamped = 1'b1;
      end else begin
        per_cyl   = heads * SECT_PER_TRACK;
        cyl       = lba / per_cyl;
        rem       = lba - cyl * per_cyl;
        hd        = rem / SECT_PER_TRACK;
        sect      = rem - hd * SECT_PER_TRACK + 32'd1;
        r.clamped = 1'b0;
      end
      sch               = ((cyl >> 2) & 32'hC0) + sect;
      r.cylinder_low    = cyl[7:0];
      r.head            = hd[7:0];
      r.sector_cyl_high = sch[7:0];
      r.heads_used      = heads[7:0];
      return r;
    endfunction

    function void note_request(logic [31:0] lba);
      chs_result_t r;
      r = translate_lba(lba);
      chs_q.push_back(r);
      requests++;
      if (r.clamped) clamped_count++;
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(chs_result_t got);
      chs_result_t want;
      if (chs_q.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      want = chs_q.pop_front();
      compare_field("cylinder_low", want.cylinder_low, got.cylinder_low);
      compare_field("head", want.head, got.head);
      compare_field("sector_cyl_high", want.sector_cyl_high, got.sector_cyl_high);
      compare_field("heads_used", want.heads_used, got.heads_used);
      compare_field("clamped", want.clamped, got.clamped);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] lba_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  cylinder_low_o;
  logic [7:0]  head_o;
  logic [7:0]  sector_cyl_high_o;
  logic [7:0]  heads_used_o;
  logic        clamped_o;

  chs_scoreboard sb;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  bit            long_stall  = 1'b0;
  int unsigned   sizes_used  = 0;

  lba_to_chs_translate i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .lba_i             (lba_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .cylinder_low_o    (cylinder_low_o),
    .head_o            (head_o),
    .sector_cyl_high_o (sector_cyl_high_o),
    .heads_used_o      (heads_used_o),
    .clamped_o         (clamped_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on demand
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        long_stall = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    chs_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(lba_i);
      if (out_valid_o && out_ready_i) begin
        got.cylinder_low    = cylinder_low_o;
        got.head            = head_o;
        got.sector_cyl_high = sector_cyl_high_o;
        got.heads_used      = heads_used_o;
        got.clamped         = clamped_o;
        sb.check_result(got);
      end
    end
  end

  task automatic send_lba(logic [31:0] lba);
    int unsigned gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    lba_i      <= lba;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    while (sb.chs_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_disk_size(logic [31:0] size);
    repeat (NUM_STAGES) @(posedge clk_i);
    cfg_wdata_i <= size;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.disk_size = size;
    sizes_used++;
  endtask

  function automatic logic [31:0] random_lba();
    logic [31:0] per_cyl;
    per_cyl = {24'd0, sb.heads_for_size(sb.disk_size)} * SECT_PER_TRACK;
    case ($urandom_range(9))
      5:       return $urandom_range(CLAMP_ADDR + 3, CLAMP_ADDR - 3);
      6, 9:    return $urandom;
      7:       return $urandom_range(0, 1100) * per_cyl + $urandom_range(0, 2) - 32'd1;
      8:       return $urandom_range(0, 259840) * SECT_PER_TRACK + $urandom_range(0, 1) * 62;
      default: return $urandom_range(0, CLAMP_ADDR - 1);
    endcase
  endfunction

  function automatic logic [31:0] phase_size(int unsigned phase);
    case (phase)
      0:  return 32'd0;
      1:  return 32'd1033199;
      2:  return 32'd1033200;
      3:  return 32'd2066399;
      4:  return 32'd2066400;
      5:  return 32'd4132799;
      6:  return 32'd4132800;
      7:  return 32'd8265599;
      8:  return 32'd8265600;
      9:  return LARGE_DISK_SIZE - 32'd1;
      10: return LARGE_DISK_SIZE;
      11: return 32'hFFFFFFFF;
      12: return $urandom;
      default: return $urandom_range(0, LARGE_DISK_SIZE);
    endcase
  endfunction

  initial begin
    logic [31:0] small_disk_lbas[11];
    logic [31:0] large_disk_lbas[7];
    sb = new();
    small_disk_lbas = '{32'd0, 32'd62, 32'd63, 32'd1007, 32'd1008,
                        32'd1031 * 32'd1008 + 32'd5, CLAMP_ADDR - 32'd1, CLAMP_ADDR,
                        32'hFFFFFFFF, 32'h80000000, 32'h00FFFFFF};
    large_disk_lbas = '{32'd0, 32'd16064, 32'd16065, CLAMP_ADDR - 32'd1, CLAMP_ADDR,
                        32'h55555555, 32'hAAAAAAAA};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset disk size first, then the largest
    foreach (small_disk_lbas[i]) send_lba(small_disk_lbas[i]);
    stop_sending();
    wait_for_results();
    write_disk_size(32'hFFFFFFFF);
    foreach (large_disk_lbas[i]) send_lba(large_disk_lbas[i]);
    stop_sending();
    wait_for_results();

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 5)
        0:       begin tx_idle_pct = 25; rx_idle_pct = 52; end
        1:       begin tx_idle_pct = 52; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      write_disk_size(phase_size(phase));
      if (phase == 2) long_stall = 1'b1;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_lba(random_lba());
        if (phase == 7 && n == ITEMS_PER_PHASE / 2) begin
          stop_sending();
          wait_for_results();
        end
      end
      stop_sending();
      wait_for_results();
    end

    repeat (NUM_STAGES * 4) @(posedge clk_i);
    $display("translated %0d addresses (%0d clamped) under %0d disk size settings",
             sb.requests, sb.clamped_count, sizes_used);
    $display("head counts 16 to 255 with their boundaries, one long output stall");
    if (sb.mismatches == 0 && sb.chs_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
